// ===== sv/wrsn_pkg.sv =====
// shared types and constants of the wpa/rsn information element parser
package wrsn_pkg;

    // element ids, suite ouis and the vendor type for wpa
    localparam logic [7:0]  ID_RSN      = 8'h30;
    localparam logic [7:0]  ID_VENDOR   = 8'hdd;
    localparam logic [7:0]  WPA_TYPE    = 8'h01;
    localparam logic [23:0] OUI_WPA     = 24'h0050f2;
    localparam logic [23:0] OUI_RSN     = 24'h000fac;

    // mask bits for a foreign oui and for the short element default
    localparam logic [15:0] BIT_PROP    = 16'h0080;
    localparam logic [15:0] BIT_DEF     = 16'h0004;

    // version bits
    localparam logic [1:0]  VER_WPA     = 2'd1;
    localparam logic [1:0]  VER_RSN     = 2'd2;

    // smallest clamped element lengths that get parsed
    localparam logic [8:0]  RSN_MIN_LEN = 9'd4;
    localparam logic [8:0]  WPA_MIN_LEN = 9'd8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // kind of the element being walked
    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_RSN  = 2'd1,
        KIND_WPA  = 2'd2
    } t_kind;

    // parse phase, one-hot
    typedef enum logic [9:0] {
        PH_ID    = 10'b00_0000_0001,
        PH_LEN   = 10'b00_0000_0010,
        PH_SKIP  = 10'b00_0000_0100,
        PH_VHDR  = 10'b00_0000_1000,
        PH_VER   = 10'b00_0001_0000,
        PH_GROUP = 10'b00_0010_0000,
        PH_PCNT  = 10'b00_0100_0000,
        PH_PLIST = 10'b00_1000_0000,
        PH_ACNT  = 10'b01_0000_0000,
        PH_ALIST = 10'b10_0000_0000
    } t_phase;

    // one classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0]  ie_byte;
        logic        first_byte;
        logic        last_byte;
        logic [10:0] total_len;
        t_kind       id_kind;
    } t_item;

    // one result
    typedef struct packed {
        logic [1:0]  ver_seen;
        logic [15:0] group_mask;
        logic [15:0] pairwise_mask;
        logic [15:0] akm_mask;
    } t_result;

endpackage

// ===== sv/wrsn_if.sv =====
// byte input and result output channel interfaces

interface wrsn_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ie_byte;
    logic        first_byte;
    logic        last_byte;
    logic [10:0] blob_length;

    modport source (output valid, ie_byte, first_byte, last_byte, blob_length, input ready);
    modport sink   (input valid, ie_byte, first_byte, last_byte, blob_length, output ready);
    modport mon    (input valid, ready, ie_byte, first_byte, last_byte, blob_length);
endinterface

interface wrsn_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  ver_seen;
    logic [15:0] group_mask;
    logic [15:0] pairwise_mask;
    logic [15:0] akm_mask;

    modport source (output valid, ver_seen, group_mask, pairwise_mask, akm_mask,
                    input ready);
    modport sink   (input valid, ver_seen, group_mask, pairwise_mask, akm_mask,
                    output ready);
    modport mon    (input valid, ready, ver_seen, group_mask, pairwise_mask, akm_mask);
endinterface

// ===== sv/wrsn_front.sv =====
// front end: accepts bytes, clamps the buffer length and classifies element ids
module wrsn_front #(
    parameter int BLOB_BYTES = 1024
) (
    wrsn_in_if.sink         i_in,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output wrsn_pkg::t_item o_item
);
    import wrsn_pkg::*;

    logic [10:0] w_total;
    t_kind       w_kind;

    // clamp the sampled length to the buffer size
    always_comb begin
        if ({6'b0, i_in.blob_length} > 17'(BLOB_BYTES)) begin
            w_total = 11'(BLOB_BYTES);
        end else begin
            w_total = i_in.blob_length;
        end
    end

    // element kind if this byte turns out to be an element id
    always_comb begin
        if (i_in.ie_byte == ID_RSN) begin
            w_kind = KIND_RSN;
        end else if (i_in.ie_byte == ID_VENDOR) begin
            w_kind = KIND_WPA;
        end else begin
            w_kind = KIND_SKIP;
        end
    end

    // handshake goes straight to the queue
    assign o_push_valid      = i_in.valid;
    assign i_in.ready        = i_push_ready;
    assign o_item.ie_byte    = i_in.ie_byte;
    assign o_item.first_byte = i_in.first_byte;
    assign o_item.last_byte  = i_in.last_byte;
    assign o_item.total_len  = w_total;
    assign o_item.id_kind    = w_kind;

endmodule

// ===== sv/wrsn_queue.sv =====
// short register queue between front and back
module wrsn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  wrsn_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output wrsn_pkg::t_item o_pop_item
);
    import wrsn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/wrsn_back.sv =====
// back end: element walk, suite parsing, mask accumulation and result register
module wrsn_back #(
    parameter int CIPHER_LIMIT = 8,
    parameter int AKM_LIMIT    = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  wrsn_pkg::t_item i_item,
    wrsn_out_if.source      o_out
);
    import wrsn_pkg::*;

    // parse state
    logic [1:0]  r_ver,   n_ver;
    logic [15:0] r_grp,   n_grp;
    logic [15:0] r_pair,  n_pair;
    logic [15:0] r_akm,   n_akm;
    logic [10:0] r_pos,   n_pos;
    logic [10:0] r_total, n_total;
    logic [8:0]  r_epos,  n_epos;
    logic [8:0]  r_elen,  n_elen;
    t_kind       r_kind,  n_kind;
    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt,   n_cnt;
    logic [8:0]  r_idx,   n_idx;
    logic [23:0] r_oui,   n_oui;

    // result register
    logic        r_out_valid;
    t_result     r_out;
    logic        w_pop;

    // a last byte waits while the result register is still held
    assign o_pop_ready = !i_item.last_byte || !r_out_valid || o_out.ready;
    assign w_pop       = i_pop_valid && o_pop_ready;

    // next parse state for the byte at the head of the queue
    always_comb begin
        logic [7:0]  v_b;
        logic [8:0]  v_n;
        logic [11:0] v_rem;
        logic [8:0]  v_len;
        logic [23:0] v_own;
        logic [18:0] v_need;
        logic        v_is_p;

        v_b     = i_item.ie_byte;
        n_ver   = r_ver;
        n_grp   = r_grp;
        n_pair  = r_pair;
        n_akm   = r_akm;
        n_pos   = r_pos;
        n_total = r_total;
        n_epos  = r_epos;
        n_elen  = r_elen;
        n_kind  = r_kind;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_oui   = r_oui;
        v_n     = '0;
        v_rem   = '0;
        v_len   = '0;
        v_need  = '0;
        v_is_p  = 1'b0;

        // first byte restarts the walk
        if (i_item.first_byte) begin
            n_ver   = '0;
            n_grp   = '0;
            n_pair  = '0;
            n_akm   = '0;
            n_pos   = '0;
            n_total = i_item.total_len;
            n_epos  = '0;
            n_elen  = '0;
            n_kind  = KIND_SKIP;
            n_cnt   = '0;
            n_phase = PH_ID;
            n_idx   = '0;
            n_oui   = '0;
        end

        v_own = (n_kind == KIND_RSN) ? OUI_RSN : OUI_WPA;

        if (n_pos < n_total) begin
            if (n_phase == PH_ID) begin
                // an id needs a length byte after it in the buffer
                if ({1'b0, n_pos} + 12'd2 <= {1'b0, n_total}) begin
                    n_kind  = i_item.id_kind;
                    n_epos  = 9'd1;
                    n_phase = PH_LEN;
                end
            end else begin
                if (n_phase == PH_LEN) begin
                    // clamp element length to what is left of the buffer
                    v_rem  = {1'b0, n_total} - {1'b0, n_pos} + 12'd1;
                    v_len  = {1'b0, v_b} + 9'd2;
                    n_elen = ({3'b0, v_len} > v_rem) ? v_rem[8:0] : v_len;
                    n_epos = 9'd2;
                    n_idx  = '0;
                    n_oui  = '0;
                    if (n_kind == KIND_RSN && n_elen >= RSN_MIN_LEN) begin
                        n_ver   = n_ver | VER_RSN;
                        n_phase = PH_VER;
                    end else if (n_kind == KIND_WPA && n_elen >= WPA_MIN_LEN) begin
                        n_phase = PH_VHDR;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else begin
                    v_n = n_epos + 9'd1;
                    case (n_phase)
                        // vendor oui and type
                        PH_VHDR: begin
                            if (n_idx < 9'd3) begin
                                n_oui = {n_oui[15:0], v_b};
                                n_idx = n_idx + 9'd1;
                            end else if (n_oui == OUI_WPA && v_b == WPA_TYPE) begin
                                n_ver   = n_ver | VER_WPA;
                                n_phase = PH_VER;
                                n_idx   = '0;
                                n_oui   = '0;
                            end else begin
                                n_phase = PH_SKIP;
                                n_idx   = '0;
                                n_oui   = '0;
                            end
                        end
                        // two version bytes, then defaults if no group suite fits
                        PH_VER: begin
                            if (n_idx == '0) begin
                                n_idx = 9'd1;
                            end else if ({1'b0, n_elen} < {1'b0, v_n} + 10'd4) begin
                                n_grp   = n_grp | BIT_DEF;
                                n_pair  = n_pair | BIT_DEF;
                                n_akm   = n_akm | BIT_DEF;
                                n_phase = PH_SKIP;
                                n_idx   = '0;
                                n_oui   = '0;
                            end else begin
                                n_phase = PH_GROUP;
                                n_idx   = '0;
                                n_oui   = '0;
                            end
                        end
                        // group suite
                        PH_GROUP: begin
                            if (n_idx < 9'd3) begin
                                n_oui = {n_oui[15:0], v_b};
                                n_idx = n_idx + 9'd1;
                            end else begin
                                if (n_oui != v_own) begin
                                    n_grp = n_grp | BIT_PROP;
                                end else if (v_b < 8'd16) begin
                                    n_grp = n_grp | (16'd1 << v_b[3:0]);
                                end
                                if ({1'b0, n_elen} < {1'b0, v_n} + 10'd2) begin
                                    n_pair  = n_pair | BIT_DEF;
                                    n_akm   = n_akm | BIT_DEF;
                                    n_phase = PH_SKIP;
                                end else begin
                                    n_phase = PH_PCNT;
                                end
                                n_idx = '0;
                                n_oui = '0;
                            end
                        end
                        // little endian suite counts
                        PH_PCNT, PH_ACNT: begin
                            v_is_p = (n_phase == PH_PCNT);
                            if (n_idx == '0) begin
                                n_cnt = {8'b0, v_b};
                                n_idx = 9'd1;
                            end else begin
                                n_cnt  = {v_b, n_cnt[7:0]};
                                v_need = {10'b0, v_n} + {1'b0, n_cnt, 2'b00};
                                n_idx  = '0;
                                n_oui  = '0;
                                if ({10'b0, n_elen} < v_need) begin
                                    n_phase = PH_SKIP;
                                end else if (v_is_p) begin
                                    if (n_cnt == '0) begin
                                        n_phase = ({1'b0, n_elen} < {1'b0, v_n} + 10'd2) ?
                                                  PH_SKIP : PH_ACNT;
                                    end else begin
                                        n_phase = PH_PLIST;
                                    end
                                end else begin
                                    n_phase = (n_cnt == '0) ? PH_SKIP : PH_ALIST;
                                end
                            end
                        end
                        // pairwise and key management suite lists
                        PH_PLIST, PH_ALIST: begin
                            v_is_p = (n_phase == PH_PLIST);
                            if (n_idx[1:0] != 2'd3) begin
                                n_oui = {n_oui[15:0], v_b};
                            end else if (v_is_p) begin
                                if (n_oui != v_own) begin
                                    n_pair = n_pair | BIT_PROP;
                                end else if (v_b <= 8'(CIPHER_LIMIT)) begin
                                    n_pair = n_pair | (16'd1 << v_b[3:0]);
                                end
                            end else begin
                                if (n_oui != v_own) begin
                                    n_akm = n_akm | BIT_PROP;
                                end else if (v_b <= 8'(AKM_LIMIT)) begin
                                    n_akm = n_akm | (16'd1 << v_b[3:0]);
                                end
                            end
                            n_idx = n_idx + 9'd1;
                            if ({9'b0, n_idx} == {n_cnt, 2'b00}) begin
                                if (v_is_p) begin
                                    n_phase = ({1'b0, n_elen} < {1'b0, v_n} + 10'd2) ?
                                              PH_SKIP : PH_ACNT;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                                n_idx = '0;
                                n_oui = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_epos = v_n;
                end
                // element done
                if (n_epos >= n_elen) begin
                    n_phase = PH_ID;
                end
            end
            n_pos = n_pos + 11'd1;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver   <= '0;
            r_grp   <= '0;
            r_pair  <= '0;
            r_akm   <= '0;
            r_pos   <= '0;
            r_total <= '0;
            r_epos  <= '0;
            r_elen  <= '0;
            r_kind  <= KIND_SKIP;
            r_phase <= PH_ID;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_oui   <= '0;
        end else if (w_pop) begin
            r_ver   <= n_ver;
            r_grp   <= n_grp;
            r_pair  <= n_pair;
            r_akm   <= n_akm;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_epos  <= n_epos;
            r_elen  <= n_elen;
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_oui   <= n_oui;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && i_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_pop && i_item.last_byte) begin
            r_out.ver_seen      <= n_ver;
            r_out.group_mask    <= n_grp;
            r_out.pairwise_mask <= n_pair;
            r_out.akm_mask      <= n_akm;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ver_seen      = r_out.ver_seen;
    assign o_out.group_mask    = r_out.group_mask;
    assign o_out.pairwise_mask = r_out.pairwise_mask;
    assign o_out.akm_mask      = r_out.akm_mask;

endmodule

// ===== sv/wpa_rsn_ie_cipher_parser_core.sv =====
// top level of the wpa/rsn information element cipher parser
// The parser takes one byte of an information element buffer per cycle while the queue has
// room and returns one result (version seen and group, pairwise and key management suite
// masks) for each byte flagged last. The front end classifies each byte and places it in a
// two-entry queue; the back end walks the element headers and updates the parse state for
// one byte per cycle, so the sustained rate is one byte per clock unless a last byte waits
// on a held result. A result is written into the output register when the back end takes
// its last byte from the queue. While a result waits on the output, bytes keep flowing; only
// a further last byte holds in the queue until the waiting result has been transferred.
module wpa_rsn_ie_cipher_parser_core #(
    parameter int CIPHER_LIMIT = 8,
    parameter int AKM_LIMIT    = 3,
    parameter int BLOB_BYTES   = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrsn_in_if.sink    i_in,
    wrsn_out_if.source o_out
);
    import wrsn_pkg::*;

    logic  w_push_valid;
    logic  w_push_ready;
    t_item w_push_item;
    logic  w_pop_valid;
    logic  w_pop_ready;
    t_item w_pop_item;

    // classification
    wrsn_front #(
        .BLOB_BYTES (BLOB_BYTES)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_item       (w_push_item)
    );

    // decoupling queue
    wrsn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_item   (w_pop_item)
    );

    // parser
    wrsn_back #(
        .CIPHER_LIMIT (CIPHER_LIMIT),
        .AKM_LIMIT    (AKM_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_item      (w_pop_item),
        .o_out       (o_out)
    );

endmodule

// ===== sv/wrsn_checker.sv =====
// port level checks of the parser and their bind to the top level
module wrsn_checker #(
    parameter int CIPHER_LIMIT = 8,
    parameter int AKM_LIMIT    = 3
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_ver,
    input logic [15:0] i_out_grp,
    input logic [15:0] i_out_pair,
    input logic [15:0] i_out_akm
);
    import wrsn_pkg::*;

    localparam logic [15:0] PAIR_OK = 16'((32'd1 << (CIPHER_LIMIT + 1)) - 32'd1) | BIT_PROP;
    localparam logic [15:0] AKM_OK  = 16'((32'd1 << (AKM_LIMIT + 1)) - 32'd1) | BIT_PROP;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ver)
            && $stable(i_out_grp) && $stable(i_out_pair)
            && $stable(i_out_akm))
        else $error("result changed while stalled");

    // masks only come from parsed elements
    a_no_version_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ver == 2'd0 |->
            i_out_grp == '0 && i_out_pair == '0 && i_out_akm == '0)
        else $error("suite mask without a parsed element");

    // pairwise selectors above the limit set no bit
    a_pair_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_pair & ~PAIR_OK) == '0)
        else $error("pairwise bit above cipher limit");

    // key management selectors above the limit set no bit
    a_akm_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_akm & ~AKM_OK) == '0)
        else $error("key management bit above limit");

endmodule

bind wpa_rsn_ie_cipher_parser_core wrsn_checker #(
    .CIPHER_LIMIT (CIPHER_LIMIT),
    .AKM_LIMIT    (AKM_LIMIT)
) u_wrsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ver   (o_out.ver_seen),
    .i_out_grp   (o_out.group_mask),
    .i_out_pair  (o_out.pairwise_mask),
    .i_out_akm   (o_out.akm_mask)
);
